// ===== rtl/core/qpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion point transform package
// Shared widths, fixed-point constants, register indexes and the coefficient
// matrix type.
// ----------------------------------------------------------------------------
package qpt_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // Quaternion components are signed Q1.14.
  localparam int QUAT_BITS = 16;
  localparam int PROD_W    = 2 * QUAT_BITS;
  // Matrix coefficients are signed Q5.28 and stay below magnitude 2^32.
  localparam int COEF_W    = PROD_W + 2;
  localparam int COEF_LO_W = COEF_W / 2;
  localparam int COEF_HI_W = COEF_W - COEF_LO_W;

  localparam int FRAC_SHIFT = 28;

  localparam int CFG_INDEX_W = 3;
  localparam int NUM_AXES    = 3;
  localparam int NUM_QUAT    = 4;
  localparam int NUM_COEF    = NUM_AXES * NUM_AXES;

  localparam logic signed [QUAT_BITS-1:0] QUAT_ONE = QUAT_BITS'(1 << (QUAT_BITS - 2));

  // Configuration register indexes; the last index has no register behind it.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_QUAT_W  = 3'd0,
    REG_QUAT_X  = 3'd1,
    REG_QUAT_Y  = 3'd2,
    REG_QUAT_Z  = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6,
    REG_SPARE   = 3'd7
  } cfg_reg_t;

  // Row-major 3x3 rotation matrix.
  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_mat_t;

endpackage

// ===== rtl/core/quaternion_point_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion point transform
// Rotates signed Q16.16 points by a Q1.14 quaternion, optionally translates
// them, and rounds and saturates each axis.
// ----------------------------------------------------------------------------
// Usage:
//   The point channel (point_valid/point_ready) carries one request per
//   point: mode, px, py, pz. The result channel (result_valid/result_ready)
//   returns out_x, out_y, out_z and overflow for each request, in order.
//   The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   quaternion and translation registers; it is ready whenever reset is low
//   and should be used only while no request is in flight.
//   One point is accepted per cycle while the output register is not
//   stalled. The datapath has seven register stages, the first one loading
//   at acceptance and the multiplier stage being split into two partial
//   products.
//   The rotation matrix is rebuilt from the registers in two stages, and a
//   request accepted right after a write still sees the new values.
//   Reset clears all stage valid bits and loads the identity quaternion and
//   zero translation. While the receiver stalls a full output register, the
//   whole pipeline holds and point_ready is low; nothing is dropped.
// ----------------------------------------------------------------------------
module quaternion_point_transform #(
  parameter int COORD_WIDTH = qpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_data,
  input  logic                              point_valid,
  output logic                              point_ready,
  input  logic                              mode,
  input  logic signed [COORD_WIDTH-1:0]     px,
  input  logic signed [COORD_WIDTH-1:0]     py,
  input  logic signed [COORD_WIDTH-1:0]     pz,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [COORD_WIDTH-1:0]     out_x,
  output logic signed [COORD_WIDTH-1:0]     out_y,
  output logic signed [COORD_WIDTH-1:0]     out_z,
  output logic                              overflow
);
  import qpt_pkg::*;

  localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  logic signed [QUAT_BITS-1:0]   quat  [NUM_QUAT];
  logic signed [COORD_WIDTH-1:0] shift [NUM_AXES];

  logic signed [PROD_W-1:0] pr_ww, pr_xx, pr_yy, pr_zz;
  logic signed [PROD_W-1:0] pr_xy, pr_wz, pr_xz, pr_wy, pr_yz, pr_wx;
  coef_mat_t                coef;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat[0]  <= QUAT_ONE;
      quat[1]  <= '0;
      quat[2]  <= '0;
      quat[3]  <= '0;
      shift[0] <= '0;
      shift[1] <= '0;
      shift[2] <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_QUAT_W:  quat[0]  <= cfg_data[QUAT_BITS-1:0];
        REG_QUAT_X:  quat[1]  <= cfg_data[QUAT_BITS-1:0];
        REG_QUAT_Y:  quat[2]  <= cfg_data[QUAT_BITS-1:0];
        REG_QUAT_Z:  quat[3]  <= cfg_data[QUAT_BITS-1:0];
        REG_SHIFT_X: shift[0] <= cfg_data;
        REG_SHIFT_Y: shift[1] <= cfg_data;
        REG_SHIFT_Z: shift[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Component products, then the expanded q*v*conj(q) matrix in Q5.28.
  always_ff @(posedge clk) begin
    pr_ww <= quat[0] * quat[0];
    pr_xx <= quat[1] * quat[1];
    pr_yy <= quat[2] * quat[2];
    pr_zz <= quat[3] * quat[3];
    pr_xy <= quat[1] * quat[2];
    pr_wz <= quat[0] * quat[3];
    pr_xz <= quat[1] * quat[3];
    pr_wy <= quat[0] * quat[2];
    pr_yz <= quat[2] * quat[3];
    pr_wx <= quat[0] * quat[1];
  end

  always_ff @(posedge clk) begin
    coef[0] <= COEF_W'(pr_ww) + COEF_W'(pr_xx) - COEF_W'(pr_yy) - COEF_W'(pr_zz);
    coef[1] <= (COEF_W'(pr_xy) - COEF_W'(pr_wz)) <<< 1;
    coef[2] <= (COEF_W'(pr_xz) + COEF_W'(pr_wy)) <<< 1;
    coef[3] <= (COEF_W'(pr_xy) + COEF_W'(pr_wz)) <<< 1;
    coef[4] <= COEF_W'(pr_ww) - COEF_W'(pr_xx) + COEF_W'(pr_yy) - COEF_W'(pr_zz);
    coef[5] <= (COEF_W'(pr_yz) - COEF_W'(pr_wx)) <<< 1;
    coef[6] <= (COEF_W'(pr_xz) - COEF_W'(pr_wy)) <<< 1;
    coef[7] <= (COEF_W'(pr_yz) + COEF_W'(pr_wx)) <<< 1;
    coef[8] <= COEF_W'(pr_ww) - COEF_W'(pr_xx) - COEF_W'(pr_yy) + COEF_W'(pr_zz);
  end

  qpt_pipe #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_pipe (
    .clk          (clk),
    .rst          (rst),
    .coef         (coef),
    .shift        (shift),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .mode         (mode),
    .px           (px),
    .py           (py),
    .pz           (pz),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .overflow     (overflow)
  );

`ifndef ASSERT_OFF
  // A stalled full output register must hold back new requests.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !point_ready)
    else $error("point accepted while the output is stalled");

  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // Overflow implies that at least one axis sits at a saturation limit.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |->
      (out_x == SAT_MAX || out_x == SAT_MIN || out_y == SAT_MAX ||
       out_y == SAT_MIN || out_z == SAT_MAX || out_z == SAT_MIN))
    else $error("overflow flagged without a saturated axis");
`endif

endmodule

// ===== rtl/core/qpt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion point transform datapath
// Seven-stage stalling pipeline: matrix multiply, translation, rounding
// and saturation of one point per cycle.
// ----------------------------------------------------------------------------
module qpt_pipe #(
  parameter int COORD_WIDTH = qpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qpt_pkg::coef_mat_t            coef,
  input  logic signed [COORD_WIDTH-1:0] shift [qpt_pkg::NUM_AXES],
  input  logic                          point_valid,
  output logic                          point_ready,
  input  logic                          mode,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] pz,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          overflow
);
  import qpt_pkg::*;

  localparam int HI_PROD_W = COORD_WIDTH + COEF_HI_W;
  localparam int LO_PROD_W = COORD_WIDTH + COEF_LO_W + 1;
  localparam int ACC_W     = COORD_WIDTH + COEF_W;
  localparam int RND_W     = ACC_W - FRAC_SHIFT;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  logic advance;

  logic v0, v1, v2, v3, v4, v5, v6;

  logic                          mode0;
  logic signed [COORD_WIDTH-1:0] p0 [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] p1 [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] t1 [NUM_AXES];
  logic signed [HI_PROD_W-1:0]   ph2 [NUM_COEF];
  logic signed [LO_PROD_W-1:0]   pl2 [NUM_COEF];
  logic signed [COORD_WIDTH-1:0] t2 [NUM_AXES];
  logic signed [ACC_W-1:0]       term3 [NUM_COEF];
  logic signed [COORD_WIDTH-1:0] t3 [NUM_AXES];
  logic signed [ACC_W-1:0]       pa4 [NUM_AXES];
  logic signed [ACC_W-1:0]       pb4 [NUM_AXES];
  logic signed [ACC_W-1:0]       acc5 [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] res6 [NUM_AXES];
  logic                          ovf6;

  logic signed [RND_W-1:0]       rnd [NUM_AXES];
  logic                          in_range [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] sat_next [NUM_AXES];
  logic                          ovf_next;

  // The whole pipeline holds while the output register is full and stalled.
  assign advance     = !v6 || result_ready;
  assign point_ready = advance && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (advance) begin
      v0 <= point_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode0 <= mode;
      p0[0] <= px;
      p0[1] <= py;
      p0[2] <= pz;
      for (int r = 0; r < NUM_AXES; r++) begin
        p1[r]   <= p0[r];
        t1[r]   <= mode0 ? shift[r] : '0;
        t2[r]   <= t1[r];
        t3[r]   <= t2[r];
      end
      // Each coefficient is split into a signed high half and an unsigned
      // low half so that no single multiplier exceeds the point width by 18.
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          ph2[r * NUM_AXES + k] <= p1[k] *
            $signed(coef[r * NUM_AXES + k][COEF_W-1:COEF_LO_W]);
          pl2[r * NUM_AXES + k] <= p1[k] *
            $signed({1'b0, coef[r * NUM_AXES + k][COEF_LO_W-1:0]});
        end
      end
      for (int i = 0; i < NUM_COEF; i++) begin
        term3[i] <= (ACC_W'(ph2[i]) <<< COEF_LO_W) + ACC_W'(pl2[i]);
      end
      // The translation sits above the fraction bits, so the rounding
      // half can be merged in with an OR.
      for (int r = 0; r < NUM_AXES; r++) begin
        pa4[r]  <= term3[r * NUM_AXES] + term3[r * NUM_AXES + 1];
        pb4[r]  <= term3[r * NUM_AXES + 2] +
                   $signed((ACC_W'(t3[r]) << FRAC_SHIFT) | ROUND_HALF);
        acc5[r] <= pa4[r] + pb4[r];
        res6[r] <= sat_next[r];
      end
      ovf6 <= ovf_next;
    end
  end

  always_comb begin
    ovf_next = 1'b0;
    for (int r = 0; r < NUM_AXES; r++) begin
      rnd[r]      = $signed(acc5[r][ACC_W-1:FRAC_SHIFT]);
      in_range[r] = (&rnd[r][RND_W-1:COORD_WIDTH-1]) || !(|rnd[r][RND_W-1:COORD_WIDTH-1]);
      if (in_range[r]) begin
        sat_next[r] = rnd[r][COORD_WIDTH-1:0];
      end else begin
        sat_next[r] = rnd[r][RND_W-1] ? SAT_MIN : SAT_MAX;
      end
      ovf_next = ovf_next || !in_range[r];
    end
  end

  assign result_valid = v6;
  assign out_x        = res6[0];
  assign out_y        = res6[1];
  assign out_z        = res6[2];
  assign overflow     = ovf6;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion point transform testbench
// Streams points through the transform under a series of quaternion and
// translation settings. Each accepted request is predicted at full precision
// (exact products, round half up, saturation) and every result is compared
// field by field in order. Both sides idle at random, and the result side
// also holds off for long stretches so the pipeline fills and stalls.
// ----------------------------------------------------------------------------
module tb;
  import qpt_pkg::*;

  localparam int CW           = qpt_pkg::COORD_WIDTH_DEF;
  localparam int QB           = qpt_pkg::QUAT_BITS;
  localparam int FRAC         = qpt_pkg::FRAC_SHIFT;
  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_POINTS = 114;
  localparam int SETTLE       = 20;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic {MODE_ROTATE = 1'b0, MODE_ROTATE_SHIFT = 1'b1} xform_mode_e;

  typedef struct {
    xform_mode_e          mode;
    logic signed [CW-1:0] px, py, pz;
    int unsigned          gap;
  } point_req_t;

  typedef struct {
    int unsigned          tag;
    logic signed [CW-1:0] x, y, z;
    logic                 ovf;
  } xform_result_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [qpt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CW-1:0]                  cfg_data = '0;
  logic                           point_valid = 1'b0;
  logic                           point_ready;
  logic                           mode = 1'b0;
  logic signed [CW-1:0]           px = '0;
  logic signed [CW-1:0]           py = '0;
  logic signed [CW-1:0]           pz = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  logic signed [CW-1:0]           out_x, out_y, out_z;
  logic                           overflow;

  quaternion_point_transform #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point_valid(point_valid), .point_ready(point_ready),
    .mode(mode), .px(px), .py(py), .pz(pz),
    .result_valid(result_valid), .result_ready(result_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .overflow(overflow)
  );

  // Register shadow used by the predictor; only changed while the block is idle.
  logic signed [QB-1:0] quat_reg [4];
  logic signed [CW-1:0] shift_reg [3];

  point_req_t    point_q [$];
  xform_result_t pending_xforms [$];

  bit          send_idle, recv_idle;
  bit          sending;
  point_req_t  cur;
  int unsigned gap_left;
  int unsigned recv_wait;
  int unsigned holds_asked, holds_served;
  int unsigned hold_cycles;

  int unsigned points_sent, results_seen, sat_results, stalled_cycles;
  int unsigned settings_used, errors;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic xform_result_t transform_point(point_req_t req, int unsigned tag);
    longint               qw, qx, qy, qz;
    longint               coef [9];
    logic signed [CW-1:0] pt [3];
    logic signed [CW-1:0] axis [3];
    logic signed [127:0]  acc, wide_c, wide_p;
    xform_result_t        res;
    int                   r, k;
    qw = quat_reg[REG_QUAT_W];
    qx = quat_reg[REG_QUAT_X];
    qy = quat_reg[REG_QUAT_Y];
    qz = quat_reg[REG_QUAT_Z];
    coef[0] = qw * qw + qx * qx - qy * qy - qz * qz;
    coef[1] = 2 * (qx * qy - qw * qz);
    coef[2] = 2 * (qx * qz + qw * qy);
    coef[3] = 2 * (qx * qy + qw * qz);
    coef[4] = qw * qw - qx * qx + qy * qy - qz * qz;
    coef[5] = 2 * (qy * qz - qw * qx);
    coef[6] = 2 * (qx * qz - qw * qy);
    coef[7] = 2 * (qy * qz + qw * qx);
    coef[8] = qw * qw - qx * qx - qy * qy + qz * qz;
    pt[0] = req.px;
    pt[1] = req.py;
    pt[2] = req.pz;
    res.tag = tag;
    res.ovf = 1'b0;
    for (r = 0; r < 3; r++) begin
      acc = '0;
      for (k = 0; k < 3; k++) begin
        wide_c = coef[r * 3 + k];
        wide_p = pt[k];
        acc = acc + wide_c * wide_p;
      end
      if (req.mode == MODE_ROTATE_SHIFT) begin
        wide_p = shift_reg[r];
        acc = acc + (wide_p <<< FRAC);
      end
      acc = (acc + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (acc[127:CW-1] != {(129 - CW){acc[127]}}) begin
        axis[r] = acc[127] ? COORD_MIN : COORD_MAX;
        res.ovf = 1'b1;
      end else begin
        axis[r] = acc[CW-1:0];
      end
    end
    res.x = axis[0];
    res.y = axis[1];
    res.z = axis[2];
    return res;
  endfunction

  // Point driver: pops requests, idles for each one's gap, holds until accepted.
  always @(posedge clk) begin
    bit fire, v_next;
    fire = point_valid && point_ready;
    v_next = point_valid && !fire;
    if (rst) begin
      v_next = 1'b0;
      sending = 1'b0;
    end else begin
      if (point_valid && !point_ready) stalled_cycles++;
      if (fire) begin
        pending_xforms.push_back(transform_point(cur, points_sent));
        points_sent++;
        sending = 1'b0;
      end
      if (!v_next) begin
        if (!sending && point_q.size() != 0) begin
          cur = point_q.pop_front();
          sending = 1'b1;
          gap_left = cur.gap;
        end
        if (sending) begin
          if (gap_left == 0) begin
            v_next = 1'b1;
            mode <= cur.mode;
            px <= cur.px;
            py <= cur.py;
            pz <= cur.pz;
          end else begin
            gap_left--;
          end
        end
      end
    end
    point_valid <= v_next;
  end

  // Long receiver hold-off, counted here so the monitor only has to obey it.
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      holds_served <= 0;
    end else if (holds_served < holds_asked) begin
      hold_cycles <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: ERROR %s", $realtime, msg);
  endtask

  // Result monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    xform_result_t want;
    bit            r_next;
    if (rst) begin
      r_next = 1'b0;
      recv_wait = 0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (pending_xforms.size() == 0) begin
          flag_error($sformatf("result x=%h y=%h z=%h ovf=%b with no request outstanding",
                               out_x, out_y, out_z, overflow));
        end else begin
          want = pending_xforms.pop_front();
          if (want.ovf) sat_results++;
          if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
              overflow !== want.ovf) begin
            flag_error($sformatf({"point %0d: expected x=%h y=%h z=%h ovf=%b, ",
                                  "got x=%h y=%h z=%h ovf=%b"},
                                 want.tag, want.x, want.y, want.z, want.ovf,
                                 out_x, out_y, out_z, overflow));
          end
        end
        recv_wait = recv_idle ? $urandom_range(0, 9) : 0;
      end
      if (hold_cycles != 0) begin
        r_next = 1'b0;
      end else if (recv_wait != 0) begin
        r_next = 1'b0;
        recv_wait--;
      end else begin
        r_next = 1'b1;
      end
    end
    result_ready <= r_next;
  end

  task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z: quat_reg[idx] = data[QB-1:0];
      REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z: shift_reg[idx - REG_SHIFT_X] = data;
      default: ;  // The spare index has no register behind it.
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Quaternion writes carry random junk above the 16 bits that are kept.
  task automatic load_config(logic signed [QB-1:0] w, x, y, z,
                             logic signed [CW-1:0] sx, sy, sz);
    logic [CW-1:0] junk;
    junk = $urandom;
    write_reg(REG_QUAT_W, {junk[CW-1:QB], w});
    junk = $urandom;
    write_reg(REG_QUAT_X, {junk[CW-1:QB], x});
    junk = $urandom;
    write_reg(REG_QUAT_Y, {junk[CW-1:QB], y});
    junk = $urandom;
    write_reg(REG_QUAT_Z, {junk[CW-1:QB], z});
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_Z, sz);
    settings_used++;
  endtask

  task automatic queue_point(xform_mode_e md, logic signed [CW-1:0] x, y, z);
    point_req_t req;
    req.mode = md;
    req.px = x;
    req.py = y;
    req.pz = z;
    req.gap = send_idle ? $urandom_range(0, 9) : 0;
    point_q.push_back(req);
  endtask

  task automatic drain();
    while (point_q.size() != 0 || sending || point_valid || pending_xforms.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom;
    if (pick < 8) return $urandom_range(0, 1 << 21) - (1 << 20);
    case ($urandom_range(0, 4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return '1;
      default: return 1;
    endcase
  endfunction

  // Style 0 keeps each component within +/-11585, 1 is fully random,
  // 2 picks corner values.
  function automatic logic signed [QB-1:0] random_quat(int unsigned style);
    case (style)
      0: return $urandom_range(0, 23170) - 11585;
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(QB-1){1'b0}}};
          1: return {1'b0, {(QB-1){1'b1}}};
          2: return '0;
          3: return qpt_pkg::QUAT_ONE;
          default: return -qpt_pkg::QUAT_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [CW-1:0] random_shift();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 25) - (1 << 24);
      2: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      default: return '0;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase, n, style;
    quat_reg[REG_QUAT_W] = qpt_pkg::QUAT_ONE;
    quat_reg[REG_QUAT_X] = '0;
    quat_reg[REG_QUAT_Y] = '0;
    quat_reg[REG_QUAT_Z] = '0;
    for (n = 0; n < 3; n++) shift_reg[n] = '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity quaternion and zero translation straight out of reset.
    queue_point(MODE_ROTATE, '0, '0, '0);
    queue_point(MODE_ROTATE, COORD_MAX, COORD_MIN, '1);
    queue_point(MODE_ROTATE_SHIFT, COORD_MIN, COORD_MAX, 1);
    queue_point(MODE_ROTATE, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
    drain();

    // A tiny scalar part turns the transform into a divide by 2^28, which
    // exposes rounding ties and translation at the output extremes.
    write_reg(REG_SPARE, '1);
    load_config(1, 0, 0, 0, 5, COORD_MIN, COORD_MAX);
    queue_point(MODE_ROTATE, 1 << 27, -(1 << 27), (1 << 27) - 1);
    queue_point(MODE_ROTATE, 3 << 27, -(3 << 27), COORD_MAX);
    queue_point(MODE_ROTATE_SHIFT, 1 << 27, '0, '0);
    queue_point(MODE_ROTATE_SHIFT, '0, -(1 << 28), 1 << 28);
    drain();

    // Corner quaternion with extreme translations: saturation both ways.
    load_config(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, COORD_MAX, COORD_MIN, '1);
    queue_point(MODE_ROTATE, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_point(MODE_ROTATE, COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(MODE_ROTATE, COORD_MAX, COORD_MIN, COORD_MAX);
    queue_point(MODE_ROTATE_SHIFT, COORD_MIN, COORD_MAX, COORD_MIN);
    queue_point(MODE_ROTATE_SHIFT, '0, '0, '0);
    queue_point(MODE_ROTATE, 1, '1, '0);
    drain();

    // Non-unit quaternion scales the point by about four.
    load_config(16'sh7FFF, 0, 0, 0, '0, '0, '0);
    queue_point(MODE_ROTATE, 1 << 29, -(1 << 29), 1 << 30);
    queue_point(MODE_ROTATE_SHIFT, 100, -100, '0);
    drain();

    // Quarter turn about z.
    load_config(11585, 0, 0, 11585, 1 << 16, -(1 << 16), 7);
    queue_point(MODE_ROTATE, 1 << 16, '0, '0);
    queue_point(MODE_ROTATE_SHIFT, '0, 1 << 16, 1 << 16);
    drain();

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      style = (phase == RAND_PHASES - 1) ? 2 : phase % 3;
      send_idle = (phase % 3 != 1);
      recv_idle = (phase % 3 != 1);
      if (phase % 4 == 2) send_idle = 1'b0;
      if (phase % 2 == 0) write_reg(REG_SPARE, $urandom);
      load_config(random_quat(style), random_quat(style), random_quat(style),
                  random_quat(style), random_shift(), random_shift(), random_shift());
      // The result side freezes while the point side keeps offering requests.
      if (phase % 4 == 2) holds_asked++;
      for (n = 0; n < PHASE_POINTS; n++)
        queue_point(xform_mode_e'($urandom_range(0, 1)),
                    random_coord(), random_coord(), random_coord());
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("Transformed %0d points under %0d register settings; %0d results checked, %0d saturated.",
             points_sent, settings_used, results_seen, sat_results);
    $display("Point input was held off for %0d cycles by result back-pressure.",
             stalled_cycles);
    if (errors == 0 && pending_xforms.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_xforms.size());
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Run did not finish within %0d cycles.", LIMIT_CYCLES);
    $display("tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/qpt_pkg.sv
rtl/core/qpt_pipe.sv
rtl/core/quaternion_point_transform.sv
test/tb.sv
